// ===== src/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode console writer: field widths,
// character codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = ATTR_W + CHAR_W;
  localparam int INDEX_W    = 11;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;

  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL     = {RESET_ATTR, BLANK_CHAR};

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the incoming request
    logic exec;        // run the latched request (put or read)
    logic copy_step;   // scroll: move one cell up a line
    logic blank_step;  // scroll: blank one cell of the bottom line
    logic clear_step;  // post-reset fill of one cell
    logic load_out;    // load the result register
  } tmcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scroll;      // exec of this put needs a scroll
    logic copy_last;   // last cell of the copy sweep
    logic scan_last;   // scan pointer at the last cell of the buffer
  } tmcw_sts_t;

endpackage

// ===== src/tmcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer for the console writer: reset clear sweep, request execution,
// scroll copy/blank sweeps and the result register handshake.
// ----------------------------------------------------------------------------
module tmcw_ctrl
  import tmcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tmcw_sts_t sts,
  output tmcw_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_BLANK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.scan_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.scroll ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) state_next = S_DRAIN;
      end
      // last copied cell is written back this cycle
      S_DRAIN: state_next = S_BLANK;
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted request did not enter execution");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.exec, cmd.copy_step, cmd.blank_step}))
    else $error("more than one buffer action in a cycle");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("request accepted during clear sweep");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("result register overwritten before taken");

endmodule

// ===== src/tmcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tmcw_datapath
// Screen buffer memory, cursor, attribute register, sweep pointer and the
// result register of the console writer.
// ----------------------------------------------------------------------------
module tmcw_datapath
  import tmcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmcw_cmd_t            cmd,
  output tmcw_sts_t            sts,
  input  logic                 cfg_write_en,
  input  logic [ATTR_W-1:0]    cfg_write_data,
  input  logic                 kind,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [INDEX_W-1:0]   cell_index,
  output logic [CELL_W-1:0]    cell_value,
  output logic [OUT_ROW_W-1:0] cursor_row,
  output logic [OUT_COL_W-1:0] cursor_col
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_COUNT = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(COPY_COUNT - 1);

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  rdata;

  logic [ATTR_W-1:0]  attr;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  scan;
  logic               wr_pend;
  logic [ADDR_W-1:0]  wr_dst;
  logic               read_hit;

  logic               item_kind;
  logic [CHAR_W-1:0]  item_char;
  logic [INDEX_W-1:0] item_idx;

  logic               is_put, is_newline, is_erase, advance, idx_ok;
  logic [COL_W-1:0]   col_dec;
  logic [ADDR_W-1:0]  row_base, put_addr;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CELL_W-1:0]  wr_data;

  always_comb begin
    is_put     = item_kind == KIND_PUT;
    is_newline = item_char == NEWLINE_CHAR;
    is_erase   = item_char == BACKSPACE_CHAR && col != '0;
    // line advance: newline, or a glyph written in the last column
    advance    = is_newline || (!is_erase && col == LAST_COL);
    idx_ok     = 32'(item_idx) < CELL_COUNT;
    col_dec    = col - COL_W'(1);
    row_base   = ADDR_W'(32'(row) * SCREEN_COLUMNS);
    put_addr   = row_base + (is_erase ? ADDR_W'(col_dec) : ADDR_W'(col));

    sts.scroll    = cmd.exec && is_put && advance && row == LAST_ROW;
    sts.copy_last = scan == LAST_COPY;
    sts.scan_last = scan == LAST_CELL;
  end

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan;
    wr_data = {attr, BLANK_CHAR};
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_data = RESET_CELL;
    end else if (wr_pend) begin
      wr_en   = 1'b1;
      wr_addr = wr_dst;
      wr_data = rdata;
    end else if (cmd.blank_step) begin
      wr_en   = 1'b1;
    end else if (cmd.exec && is_put && !is_newline) begin
      wr_en   = 1'b1;
      wr_addr = put_addr;
      wr_data = is_erase ? {attr, BLANK_CHAR} : {attr, item_char};
    end
  end

  always_comb begin
    rd_en   = cmd.copy_step || (cmd.exec && !is_put && idx_ok);
    rd_addr = cmd.copy_step ? scan + ADDR_W'(SCREEN_COLUMNS) : ADDR_W'(item_idx);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind <= kind;
      item_char <= char_code;
      item_idx  <= cell_index;
    end
    if (cmd.copy_step) wr_dst <= scan;
    if (cmd.exec) read_hit <= !is_put && idx_ok;
    if (cmd.load_out) begin
      cell_value <= read_hit ? rdata : '0;
      cursor_row <= OUT_ROW_W'(row);
      cursor_col <= OUT_COL_W'(col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr    <= RESET_ATTR;
      col     <= '0;
      row     <= '0;
      scan    <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cfg_write_en) attr <= cfg_write_data;
      wr_pend <= cmd.copy_step;
      if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
        scan <= sts.scan_last ? '0 : scan + ADDR_W'(1);
      end
      if (cmd.exec && is_put) begin
        if (is_erase) begin
          col <= col_dec;
        end else if (advance) begin
          col <= '0;
          if (row != LAST_ROW) row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    row <= LAST_ROW && col <= LAST_COL)
    else $error("cursor outside screen");

  a_copy_write_alone: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> !(cmd.clear_step || cmd.blank_step || cmd.exec))
    else $error("copy write-back collides with another write");

  a_scroll_from_last_row: assert property (@(posedge clk) disable iff (rst)
    sts.scroll |=> row == LAST_ROW && col == '0 && scan == '0)
    else $error("scroll started from wrong cursor or sweep position");

  a_copy_reaches_bottom: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step && sts.copy_last |=> scan == ADDR_W'(COPY_COUNT))
    else $error("blank sweep does not start at bottom line");

endmodule

// ===== src/text_mode_console_writer.sv =====
// Sequence: a request is taken in idle and executed, and its result is loaded
//   into the result register; a put that scrolls first moves the buffer up a
//   line and blanks the bottom line, one buffer cell moved or blanked per cycle
//   over the single write port. A new request is taken only after that load.
// Reset: synchronous; after rst the buffer is filled with blanks in attribute
//   0x07, one cell a cycle, with in_ready held low.
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text-mode console engine: screen buffer with cursor, wrap, newline,
// backspace and scroll, plus cell read-back.
// ----------------------------------------------------------------------------
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [ATTR_W-1:0]    cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [INDEX_W-1:0]   cell_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CELL_W-1:0]    cell_value,
  output logic [OUT_ROW_W-1:0] cursor_row,
  output logic [OUT_COL_W-1:0] cursor_col
);

  tmcw_cmd_t cmd;
  tmcw_sts_t sts;

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .kind           (kind),
    .char_code      (char_code),
    .cell_index     (cell_index),
    .cell_value     (cell_value),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col)
  );

endmodule

// ===== tb/sv/text_mode_console_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_tb
// Self-checking bench for the console writer. It drives put and read requests
// with random gaps and output stalls, predicts each result from its own copy
// of the screen, cursor and attribute, and compares every result field by
// field. The attribute register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
import tmcw_pkg::*;

typedef struct packed {
  logic [CELL_W-1:0]    value;
  logic [OUT_ROW_W-1:0] row;
  logic [OUT_COL_W-1:0] col;
} console_result_t;

class console_scoreboard #(int COLS = 80, int ROWS = 25);
  logic [CELL_W-1:0] screen [ROWS*COLS];
  int unsigned       row;
  int unsigned       col;
  logic [ATTR_W-1:0] attr;
  console_result_t   expected_q[$];
  int unsigned       mismatch_count;
  int unsigned       checked_count;
  int unsigned       scroll_count;
  int unsigned       erase_count;
  int unsigned       glyph_bs_count;
  int unsigned       oob_read_count;

  function new();
    foreach (screen[i]) screen[i] = RESET_CELL;
    row = 0;
    col = 0;
    attr = RESET_ATTR;
    mismatch_count = 0;
    checked_count = 0;
    scroll_count = 0;
    erase_count = 0;
    glyph_bs_count = 0;
    oob_read_count = 0;
  endfunction

  function void set_attribute(logic [ATTR_W-1:0] value);
    attr = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // newline or wrap; scrolls the buffer up when leaving the bottom row
  function void next_line();
    col = 0;
    row++;
    if (row >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i+COLS];
      for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen[i] = {attr, BLANK_CHAR};
      row = ROWS - 1;
      scroll_count++;
    end
  endfunction

  function void note_request(logic k, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
    console_result_t res;
    res.value = '0;
    if (k == KIND_PUT) begin
      if (ch == NEWLINE_CHAR) begin
        next_line();
      end else if (ch == BACKSPACE_CHAR && col > 0) begin
        col--;
        screen[row*COLS + col] = {attr, BLANK_CHAR};
        erase_count++;
      end else begin
        // backspace at column 0 lands here and is stored as a glyph
        if (ch == BACKSPACE_CHAR) glyph_bs_count++;
        screen[row*COLS + col] = {attr, ch};
        col++;
        if (col >= COLS) next_line();
      end
    end else if (idx < ROWS*COLS) begin
      res.value = screen[idx];
    end else begin
      oob_read_count++;
    end
    res.row = row[OUT_ROW_W-1:0];
    res.col = col[OUT_COL_W-1:0];
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [CELL_W-1:0] value, logic [OUT_ROW_W-1:0] r,
                             logic [OUT_COL_W-1:0] c);
    console_result_t exp_res;
    if (expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] unexpected result: cell %h row %0d col %0d", $time, value, r, c);
      return;
    end
    exp_res = expected_q.pop_front();
    checked_count++;
    if (value !== exp_res.value || r !== exp_res.row || c !== exp_res.col) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] mismatch: expected cell %h row %0d col %0d, got cell %h row %0d col %0d",
                 $time, exp_res.value, exp_res.row, exp_res.col, value, r, c);
    end
  endfunction
endclass

module text_mode_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int HOLD_CYCLES    = 400;
  // budget covers the clearing pass, ~950 requests with gaps and stalls and a
  // few dozen scrolls; the limit leaves plenty of margin
  localparam int CYCLE_LIMIT    = 1_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [ATTR_W-1:0]    cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = KIND_PUT;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [INDEX_W-1:0]   cell_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    cell_value;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_col;

  logic hold_start = 1'b0;
  int   hold_left = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   sent_count = 0;
  int   cycles;

  console_scoreboard #(SCREEN_COLUMNS, SCREEN_ROWS) sb;

  text_mode_console_writer #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .char_code     (char_code),
    .cell_index    (cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_value    (cell_value),
    .cursor_row    (cursor_row),
    .cursor_col    (cursor_col)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(cell_value, cursor_row, cursor_col);
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(input logic k, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(k, ch, idx);
    sent_count++;
  endtask

  task automatic send_random_request();
    int                 sel;
    int                 newline_pct;
    logic               k;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    k   = ($urandom_range(99) < 40) ? KIND_READ : KIND_PUT;
    ch  = CHAR_W'($urandom_range(255));
    idx = INDEX_W'($urandom_range(2047));
    if (k == KIND_PUT) begin
      // newlines are rarer on the bottom row: each one there costs a scroll
      newline_pct = (sb.row == SCREEN_ROWS - 1) ? 4 : 14;
      sel = $urandom_range(99);
      if (sel < newline_pct)
        ch = NEWLINE_CHAR;
      else if (sel < newline_pct + 8)
        ch = BACKSPACE_CHAR;
      else if (sel >= newline_pct + 20)
        ch = CHAR_W'($urandom_range(8'h7E, 8'h20));
    end else begin
      sel = $urandom_range(99);
      if (sel < 40)
        idx = INDEX_W'(sb.row * SCREEN_COLUMNS + $urandom_range(SCREEN_COLUMNS - 1));
      else if (sel < 55)
        idx = INDEX_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS +
                       $urandom_range(SCREEN_COLUMNS - 1));
    end
    send_request(k, ch, idx);
  endtask

  task automatic run_random_phase(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) send_random_request();
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_for_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_attribute(value);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset contents, read range edges, high bytes, backspace both ways
    send_request(KIND_READ, 8'h00, 11'd0);
    send_request(KIND_READ, 8'hFF, 11'd1999);
    send_request(KIND_READ, 8'h00, 11'd2000);
    send_request(KIND_READ, 8'h00, 11'd2047);
    send_request(KIND_PUT, 8'h48, 11'd0);
    send_request(KIND_PUT, 8'hFF, 11'd2047);
    send_request(KIND_PUT, 8'h80, 11'd0);
    send_request(KIND_PUT, 8'h00, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd1);
    send_request(KIND_PUT, BACKSPACE_CHAR, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd3);
    send_request(KIND_PUT, NEWLINE_CHAR, 11'd0);
    send_request(KIND_PUT, BACKSPACE_CHAR, 11'd0);
    send_request(KIND_PUT, 8'h7F, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd80);
    in_valid <= 1'b0;

    write_attribute(8'hFF);
    send_request(KIND_PUT, 8'h41, 11'd0);
    send_request(KIND_PUT, BACKSPACE_CHAR, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd82);
    in_valid <= 1'b0;

    write_attribute(8'h00);
    send_request(KIND_PUT, 8'h7A, 11'd0);
    send_request(KIND_PUT, NEWLINE_CHAR, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd82);
    send_request(KIND_READ, 8'h00, 11'd160);
    in_valid <= 1'b0;

    write_attribute(ATTR_W'($urandom_range(255)));
    run_random_phase(190, 0, 0);
    write_attribute(8'hFF);
    run_random_phase(190, 71, 0);
    write_attribute(ATTR_W'($urandom_range(255)));
    run_random_phase(190, 0, 71);
    write_attribute(8'h00);
    run_random_phase(190, 32, 32);

    // long output hold-off while requests keep coming
    write_attribute(ATTR_W'($urandom_range(255)));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    run_random_phase(190, 0, 20);

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("sent %0d requests, checked %0d results, %0d mismatches",
             sent_count, sb.checked_count, sb.mismatch_count);
    $display("scrolls %0d, backspace erases %0d, backspace glyphs %0d, out-of-range reads %0d",
             sb.scroll_count, sb.erase_count, sb.glyph_bs_count, sb.oob_read_count);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tmcw_pkg.sv
src/tmcw_ctrl.sv
src/tmcw_datapath.sv
src/text_mode_console_writer.sv
tb/sv/text_mode_console_writer_tb.sv
